FILE: design/dfs_pkg.sv
`default_nettype none

package dfs_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ARG_W       = 32;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned DIG_DEPTH = 11;
  localparam int unsigned DIG_IDX_W = $clog2(DIG_DEPTH);
  localparam int unsigned DIGIT_W   = 4;

  // divide by ten through the reciprocal, exact for any 32-bit value
  localparam logic [ARG_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

  typedef struct packed {
    logic                 start;
    logic [DIG_IDX_W-1:0] rd_idx;
  } conv_ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic                 neg;
    logic [DIG_IDX_W-1:0] ndig;
  } conv_status_t;

endpackage

`default_nettype wire

FILE: design/dfs_digit_unit.sv
`default_nettype none

module dfs_digit_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dfs_pkg::conv_ctrl_t               ctrl,
  input  wire logic [dfs_pkg::ARG_W-1:0]         arg,
  output dfs_pkg::conv_status_t                  status,
  output logic [dfs_pkg::DIGIT_W-1:0]            rd_digit
);

  localparam int unsigned AW = dfs_pkg::ARG_W;
  localparam int unsigned IW = dfs_pkg::DIG_IDX_W;

  logic                         busy_r;
  logic                         neg_r;
  logic [AW-1:0]                mag_r;
  logic [IW-1:0]                k_r;
  logic [dfs_pkg::DIGIT_W-1:0]  dig_r [dfs_pkg::DIG_DEPTH];

  logic [2*AW-1:0]              prod;
  logic [AW-1:0]                quot;
  logic [AW-1:0]                quot_x10;
  logic [AW-1:0]                rem;
  logic                         last_digit;

  always_comb begin
    prod       = {{AW{1'b0}}, mag_r} * {{AW{1'b0}}, dfs_pkg::RECIP_10};
    quot       = AW'(prod[2*AW-1:dfs_pkg::RECIP_SHIFT]);
    quot_x10   = (quot << 3) + (quot << 1);
    rem        = mag_r - quot_x10;
    last_digit = (quot == '0) || (k_r == IW'(dfs_pkg::DIG_DEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctrl.start) begin
      busy_r <= 1'b1;
    end else if (busy_r) begin
      busy_r <= !last_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      neg_r <= arg[AW-1];
      mag_r <= arg[AW-1] ? (AW'(0) - arg) : arg;
      k_r   <= '0;
    end else if (busy_r) begin
      dig_r[k_r] <= rem[dfs_pkg::DIGIT_W-1:0];
      mag_r      <= quot;
      k_r        <= k_r + IW'(1);
    end
  end

  assign status.busy = busy_r;
  assign status.neg  = neg_r;
  assign status.ndig = k_r;
  assign rd_digit    = dig_r[ctrl.rd_idx];

endmodule

`default_nettype wire

FILE: design/decimal_format_streamer_unit.sv
`default_nettype none

// Formats a byte stream printf-style. Each input item carries one format byte and a
// signed 32-bit argument. An ordinary byte passes through S_CHAR and the output
// register as one item; a '%' is swallowed; '%d' prints the argument in signed
// decimal. The digits come from one shared divide-by-ten unit (reciprocal
// multiply), one digit per cycle, and then leave one character per cycle while
// the output is taken, after a minus sign if the argument is negative. A zero byte
// closes the string with a NUL item marked tlast carrying the character count and
// overflow flag. in_tready is high only while no item is being worked on; a full
// output register holds until taken. At most MAX_LEN-1 characters leave per string.
module decimal_format_streamer_unit #(
  parameter int unsigned MAX_LEN = dfs_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // fmt_char[7:0], argument[39:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // out_char[7:0], length[17:8], overflow[18]
  output logic             out_tlast
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN);
  localparam int unsigned CW    = dfs_pkg::CHAR_W;
  localparam int unsigned IW    = dfs_pkg::DIG_IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHAR = 6'b000010,
    S_CONV = 6'b000100,
    S_SIGN = 6'b001000,
    S_DIG  = 6'b010000,
    S_TERM = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       pct_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       ovf_r;
  logic [CW-1:0]              char_r;
  logic [IW-1:0]              idx_r;

  logic                       out_valid_r;
  logic [CW-1:0]              out_char_r;
  logic                       out_last_r;
  logic [dfs_pkg::LEN_W-1:0]  out_len_r;
  logic                       out_ovf_r;

  dfs_pkg::conv_ctrl_t        ctrl;
  dfs_pkg::conv_status_t      st;
  logic [dfs_pkg::DIGIT_W-1:0] digit;

  logic [CW-1:0]              fmt;
  logic [dfs_pkg::ARG_W-1:0]  arg;
  logic                       accept;
  logic                       slot_free;
  logic                       full;
  logic                       put_req;
  logic                       put_go;
  logic                       emit;
  logic                       term_go;
  logic [CW-1:0]              put_val;

  dfs_digit_unit u_digit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .arg      (arg),
    .status   (st),
    .rd_digit (digit)
  );

  always_comb begin
    fmt          = in_tdata[7:0];
    arg          = in_tdata[39:8];
    in_tready    = (state_r == S_IDLE);
    accept       = in_tvalid && in_tready;
    slot_free    = !out_valid_r || out_tready;
    full         = (cnt_r >= CNT_W'(MAX_LEN - 1));
    ctrl.start   = accept && pct_r && (fmt == dfs_pkg::CHAR_D);
    ctrl.rd_idx  = idx_r - IW'(1);
    put_req      = (state_r == S_CHAR) || (state_r == S_SIGN) || (state_r == S_DIG);
    put_go       = put_req && (full || slot_free);
    emit         = put_req && !full && slot_free;
    term_go      = (state_r == S_TERM) && slot_free;
    put_val      = char_r;
    if (state_r == S_SIGN) begin
      put_val = dfs_pkg::CHAR_MINUS;
    end else if (state_r == S_DIG) begin
      put_val = dfs_pkg::CHAR_ZERO + CW'(digit);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (fmt == dfs_pkg::CHAR_NUL) begin
            state_nxt = S_TERM;
          end else if (pct_r) begin
            state_nxt = (fmt == dfs_pkg::CHAR_D) ? S_CONV : S_CHAR;
          end else if (fmt != dfs_pkg::CHAR_PERCENT) begin
            state_nxt = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        if (put_go) state_nxt = S_IDLE;
      end
      S_CONV: begin
        if (!st.busy) state_nxt = st.neg ? S_SIGN : S_DIG;
      end
      S_SIGN: begin
        if (put_go) state_nxt = S_DIG;
      end
      S_DIG: begin
        if (put_go && (idx_r == IW'(1))) state_nxt = S_IDLE;
      end
      S_TERM: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pct_r       <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pct_r <= (fmt != dfs_pkg::CHAR_NUL) && !pct_r && (fmt == dfs_pkg::CHAR_PERCENT);
      end
      if (term_go) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (put_go) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (emit || term_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= fmt;
    end
    if ((state_r == S_CONV) && !st.busy) begin
      idx_r <= st.ndig;
    end else if ((state_r == S_DIG) && put_go) begin
      idx_r <= idx_r - IW'(1);
    end
    if (emit) begin
      out_char_r <= put_val;
      out_last_r <= 1'b0;
      out_len_r  <= '0;
      out_ovf_r  <= 1'b0;
    end else if (term_go) begin
      out_char_r <= dfs_pkg::CHAR_NUL;
      out_last_r <= 1'b1;
      out_len_r  <= dfs_pkg::LEN_W'(cnt_r);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_ovf_r, out_len_r, out_char_r};

  ap_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN || state_r == S_DIG) |-> !st.busy)
    else $error("digit readout while conversion still running");

  ap_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG) |-> (idx_r != '0))
    else $error("digit readout with no digits left");

  ap_last_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[7:0] == dfs_pkg::CHAR_NUL))
    else $error("terminating item carries a non-zero character");

  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    put_go |-> (cnt_r <= CNT_W'(MAX_LEN - 1)))
    else $error("character count beyond limit");

  ap_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    term_go |=> ((cnt_r == '0) && !ovf_r && !pct_r))
    else $error("string state not cleared after terminator");

endmodule

`default_nettype wire
